@@ rtl/core/ps2h_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2h_pkg
// Shared types and frame constants for the PS/2 host frame engine.
// ----------------------------------------------------------------------------
package ps2h_pkg;

  localparam int unsigned DataBits   = 8;
  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] DataEnd    = 4'd8;
  localparam logic [PosW-1:0] ParityPos  = 4'd9;
  localparam logic [PosW-1:0] StopPos    = 4'd10;
  localparam logic [PosW-1:0] FrameEdges = 4'd11;

  typedef enum logic [1:0] {
    RxOk        = 2'd0,
    RxStartBad  = 2'd1,
    RxParityBad = 2'd2,
    RxStopBad   = 2'd3
  } rx_err_e;

  typedef enum logic {
    OpClockEdge = 1'b0,
    OpSend      = 1'b1
  } op_e;

  typedef struct packed {
    logic                operation;
    logic                data_line;
    logic [DataBits-1:0] send_byte;
  } in_t;

  typedef struct packed {
    logic                request_to_send;
    logic                data_drive_enable;
    logic                data_drive_level;
    logic                byte_valid;
    logic [DataBits-1:0] received_byte;
    logic [1:0]          receive_error;
    logic                send_done;
    logic                send_acked;
  } out_t;

endpackage

@@ rtl/core/ps2_host_frame_engine.sv @@
// ----------------------------------------------------------------------------
// ps2_host_frame_engine
// Host side of the PS/2 keyboard link: one event per beat, one result per beat.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//
// One beat per cycle while in_stall_o is low; each beat's result is registered.
// Frame state updates on the accepting edge from short per-edge logic.
// A two-entry output buffer (result register plus skid) absorbs one stalled
// result; input stalls only while the skid entry is full.
// Asynchronous active-low reset clears frame state and both buffer valid flags.
// ----------------------------------------------------------------------------
module ps2_host_frame_engine
  import ps2h_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic                sending_q, sending_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [DataBits-1:0] shift_q, shift_d;
  logic                par_q, par_d;
  logic                start_bad_q, start_bad_d;
  logic                parity_bad_q, parity_bad_d;

  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;
  out_t res;
  logic accept;
  logic [2:0] pidx;

  assign accept = in_valid_i && !in_stall_o;
  assign pidx   = 3'(pos_q - 4'd1);

  always_comb begin
    sending_d    = sending_q;
    pos_d        = pos_q;
    shift_d      = shift_q;
    par_d        = par_q;
    start_bad_d  = start_bad_q;
    parity_bad_d = parity_bad_q;
    res          = '0;
    if (in_data_i.operation == OpSend) begin
      sending_d             = 1'b1;
      pos_d                 = '0;
      shift_d               = in_data_i.send_byte;
      par_d                 = 1'b0;
      start_bad_d           = 1'b0;
      parity_bad_d          = 1'b0;
      res.request_to_send   = 1'b1;
      res.data_drive_enable = 1'b1;
    end else if (sending_q) begin
      if (pos_q < DataEnd) begin
        shift_d               = shift_q >> 1;
        par_d                 = par_q ^ shift_q[0];
        res.data_drive_enable = 1'b1;
        res.data_drive_level  = shift_q[0];
        pos_d                 = pos_q + 4'd1;
      end else if (pos_q == DataEnd) begin
        res.data_drive_enable = 1'b1;
        res.data_drive_level  = ~par_q;
        pos_d                 = ParityPos;
      end else if (pos_q == ParityPos) begin
        res.data_drive_enable = 1'b1;
        res.data_drive_level  = 1'b1;
        pos_d                 = StopPos;
      end else begin
        res.send_done  = 1'b1;
        res.send_acked = ~in_data_i.data_line;
        sending_d      = 1'b0;
        pos_d          = '0;
      end
    end else begin
      if (pos_q == '0 || pos_q >= FrameEdges) begin
        start_bad_d  = in_data_i.data_line;
        parity_bad_d = 1'b0;
        shift_d      = '0;
        par_d        = 1'b0;
        pos_d        = 4'd1;
      end else if (pos_q <= DataEnd) begin
        shift_d[pidx] = shift_q[pidx] | in_data_i.data_line;
        par_d         = par_q ^ in_data_i.data_line;
        pos_d         = pos_q + 4'd1;
      end else if (pos_q == ParityPos) begin
        parity_bad_d = (in_data_i.data_line == par_q);
        pos_d        = StopPos;
      end else begin
        res.byte_valid    = 1'b1;
        res.received_byte = shift_q;
        if (start_bad_q) begin
          res.receive_error = RxStartBad;
        end else if (parity_bad_q) begin
          res.receive_error = RxParityBad;
        end else if (!in_data_i.data_line) begin
          res.receive_error = RxStopBad;
        end else begin
          res.receive_error = RxOk;
        end
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q    <= 1'b0;
      pos_q        <= '0;
      shift_q      <= '0;
      par_q        <= 1'b0;
      start_bad_q  <= 1'b0;
      parity_bad_q <= 1'b0;
    end else if (accept) begin
      sending_q    <= sending_d;
      pos_q        <= pos_d;
      shift_q      <= shift_d;
      par_q        <= par_d;
      start_bad_q  <= start_bad_d;
      parity_bad_q <= parity_bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= StopPos)
    else $error("frame position beyond the stop edge");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.byte_valid && out_q.send_done))
    else $error("receive and send completion in one result");

  a_send_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.operation == OpSend) |=> (sending_q && pos_q == '0))
    else $error("send request did not restart the frame");

endmodule
